@@ src/jst_pkg.sv @@
// Shared types, sizes and codes of the job slot table.
package jst_pkg;

  localparam int SLOTS = 16;
  localparam int PID_W = 22;
  localparam int NUM_W = 5;
  localparam int RS_W = 2;
  localparam int OP_W = 3;
  localparam int STAT_W = 2;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND_PID = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_NUM = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_STATE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND_FG = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  localparam logic [RS_W-1:0] RS_UNDEF = 2'd0;
  localparam logic [RS_W-1:0] RS_FG = 2'd1;
  localparam logic [RS_W-1:0] RS_BG = 2'd2;
  localparam logic [RS_W-1:0] RS_STOPPED = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0] proc_id;
    logic [NUM_W-1:0] number;
    logic [RS_W-1:0]  state;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } slot_wr_t;

endpackage

@@ src/jst_in_if.sv @@
// Request channel of the job slot table.
interface jst_in_if;
  import jst_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [PID_W-1:0] proc_id;
  logic [NUM_W-1:0] job_number;
  logic [RS_W-1:0]  run_state;

  modport source (output valid, output opcode, output proc_id, output job_number,
                  output run_state, input ready);
  modport sink (input valid, input opcode, input proc_id, input job_number,
                input run_state, output ready);
endinterface

@@ src/jst_out_if.sv @@
// Result channel of the job slot table.
interface jst_out_if;
  import jst_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PID_W-1:0]  found_proc_id;
  logic [NUM_W-1:0]  found_job_number;
  logic [RS_W-1:0]   found_state;

  modport source (output valid, output status, output found_proc_id,
                  output found_job_number, output found_state, input ready);
  modport sink (input valid, input status, input found_proc_id,
                input found_job_number, input found_state, output ready);
endinterface

@@ src/jst_slot_store.sv @@
// Slot register file with one indexed read and one write per cycle.
module jst_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [jst_pkg::IDX_W-1:0]     rd_idx,
  output jst_pkg::slot_t                rd_data,
  input  jst_pkg::slot_wr_t             wr
);
  import jst_pkg::*;

  slot_t slots_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots_r[i] <= '0;
      end
    end else if (wr.en) begin
      slots_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = slots_r[rd_idx];

endmodule

@@ src/job_slot_table_core.sv @@
// Job slot table: sequencer that scans the slot store one slot per cycle.
//
//   channel | dir | payload
//   in_ch   | in  | opcode, proc_id, job_number, run_state
//   out_ch  | out | status, found_proc_id, found_job_number, found_state
//
// A transaction passes the accept, a scan of the slots up to the first match (at
// most SLOTS slots), after a delete a scan of all SLOTS slots to find the largest
// job number left, and the load of the result register; a bad argument skips the scans.
// The slot comparator and the read port of the slot store set the pace of a scan.
// Reset clears every slot, sets the next job number to one and empties the result.
// A stalled result holds; the next request is taken while it waits.
module job_slot_table_core (
  input  logic clk,
  input  logic rst_n,
  jst_in_if.sink    in_ch,
  jst_out_if.source out_ch
);
  import jst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MAX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [NUM_W-1:0] SLOTS_NUM = NUM_W'(SLOTS);
  localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1);

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [NUM_W-1:0]  next_r, next_nxt;
  logic [NUM_W-1:0]  top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  pid_r;
  logic [NUM_W-1:0]  jn_r;
  logic [RS_W-1:0]   rs_r;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  slot_t             res_slot_r, res_slot_nxt;
  logic [STAT_W-1:0] out_status_r;
  slot_t             out_slot_r;

  slot_t             rd_data;
  slot_wr_t          wr;
  logic              accept;
  logic              arg_bad;
  logic              hit;
  logic              out_free;
  logic [NUM_W-1:0]  next_inc;
  logic [NUM_W-1:0]  top_max;

  jst_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx_r),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    unique case (in_ch.opcode) inside
      OP_ADD, OP_DEL, OP_FIND_PID, OP_SET_STATE: arg_bad = (in_ch.proc_id == '0);
      OP_FIND_NUM: arg_bad = (in_ch.job_number == '0);
      OP_FIND_FG: arg_bad = 1'b0;
      default: arg_bad = 1'b1;
    endcase
  end

  always_comb begin
    unique case (op_r) inside
      OP_ADD: hit = (rd_data.proc_id == '0);
      OP_DEL, OP_FIND_PID, OP_SET_STATE: hit = (rd_data.proc_id == pid_r);
      OP_FIND_NUM: hit = (rd_data.number == jn_r);
      OP_FIND_FG: hit = (rd_data.state == RS_FG);
      default: hit = 1'b0;
    endcase
  end

  assign next_inc = next_r + NUM_ONE;
  assign top_max = (rd_data.number > top_r) ? rd_data.number : top_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    next_nxt = next_r;
    top_nxt = top_r;
    res_status_nxt = res_status_r;
    res_slot_nxt = res_slot_r;
    out_valid_nxt = out_valid_r;
    wr = '0;
    wr.idx = idx_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          if (arg_bad) begin
            res_status_nxt = STAT_INVALID;
            res_slot_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_nxt = STAT_OK;
          res_slot_nxt = rd_data;
          state_nxt = S_DONE;
          unique case (op_r) inside
            OP_ADD: begin
              wr.en = 1'b1;
              wr.data = '{proc_id: pid_r, number: next_r, state: rs_r};
              res_slot_nxt = wr.data;
              if (next_inc > SLOTS_NUM || next_inc == '0) begin
                next_nxt = NUM_ONE;
              end else begin
                next_nxt = next_inc;
              end
            end
            OP_DEL: begin
              wr.en = 1'b1;
              wr.data = '0;
              top_nxt = NUM_ONE;
              idx_nxt = '0;
              state_nxt = S_MAX;
            end
            OP_SET_STATE: begin
              wr.en = 1'b1;
              wr.data = '{proc_id: rd_data.proc_id, number: rd_data.number, state: rs_r};
              res_slot_nxt = wr.data;
            end
            default: begin
            end
          endcase
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = (op_r == OP_ADD) ? STAT_FULL : STAT_NOT_FOUND;
          res_slot_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_MAX: begin
        top_nxt = top_max;
        if (idx_r == LAST_IDX) begin
          next_nxt = top_max + NUM_ONE;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      next_r <= NUM_ONE;
      top_r <= NUM_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      next_r <= next_nxt;
      top_r <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_ch.opcode;
      pid_r <= in_ch.proc_id;
      jn_r <= in_ch.job_number;
      rs_r <= in_ch.run_state;
    end
    res_status_r <= res_status_nxt;
    res_slot_r <= res_slot_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r <= res_slot_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.found_proc_id = out_slot_r.proc_id;
  assign out_ch.found_job_number = out_slot_r.number;
  assign out_ch.found_state = out_slot_r.state;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Result appeared without a finished transaction.");

  a_failed_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_OK |-> out_slot_r == '0)
    else $error("Failed transaction reports slot contents.");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_DONE |-> !wr.en)
    else $error("Slot write outside a scan.");

endmodule

@@ bench/job_slot_table_core_checker.sv @@
// Checker that predicts every job table result and compares it with the block's output.
`timescale 1ns / 1ps

module job_slot_table_core_checker (
  input  logic      clk,
  input  logic      rst_n,
  jst_in_if         in_ch,
  jst_out_if        out_ch,
  output int        fail_count,
  output int        outstanding
);
  import jst_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  proc_id;
    logic [NUM_W-1:0]  number;
    logic [RS_W-1:0]   state;
  } job_result_t;

  logic [PID_W-1:0] slot_pid[SLOTS];
  logic [NUM_W-1:0] slot_num[SLOTS];
  logic [RS_W-1:0]  slot_rs[SLOTS];
  logic [NUM_W-1:0] next_num;

  job_result_t expected_results[$];

  function automatic int first_pid_slot(input logic [PID_W-1:0] pid);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_pid[i] == pid) return i;
    end
    return -1;
  endfunction

  function automatic job_result_t run_job_op(input logic [OP_W-1:0] op,
                                             input logic [PID_W-1:0] pid,
                                             input logic [NUM_W-1:0] jn,
                                             input logic [RS_W-1:0] rs);
    job_result_t r;
    int hit;
    int top_num;
    r = '0;
    r.status = STAT_INVALID;
    hit = -1;
    case (op) inside
      OP_ADD: begin
        if (pid != '0) begin
          hit = first_pid_slot('0);
          if (hit < 0) begin
            r.status = STAT_FULL;
          end else begin
            slot_pid[hit] = pid;
            slot_rs[hit] = rs;
            slot_num[hit] = next_num;
            next_num = next_num + 1'b1;
            if (next_num > SLOTS || next_num == '0) next_num = NUM_W'(1);
            r = '{STAT_OK, slot_pid[hit], slot_num[hit], slot_rs[hit]};
          end
        end
      end
      OP_DEL: begin
        if (pid != '0) begin
          hit = first_pid_slot(pid);
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r = '{STAT_OK, slot_pid[hit], slot_num[hit], slot_rs[hit]};
            slot_pid[hit] = '0;
            slot_num[hit] = '0;
            slot_rs[hit] = RS_UNDEF;
            top_num = 1;
            for (int i = 0; i < SLOTS; i++) begin
              if (int'(slot_num[i]) > top_num) top_num = int'(slot_num[i]);
            end
            next_num = NUM_W'(top_num + 1);
          end
        end
      end
      OP_FIND_PID, OP_SET_STATE: begin
        if (pid != '0) begin
          hit = first_pid_slot(pid);
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            if (op == OP_SET_STATE) slot_rs[hit] = rs;
            r = '{STAT_OK, slot_pid[hit], slot_num[hit], slot_rs[hit]};
          end
        end
      end
      OP_FIND_NUM: begin
        if (jn != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_num[i] == jn) hit = i;
          end
          if (hit < 0) r.status = STAT_NOT_FOUND;
          else r = '{STAT_OK, slot_pid[hit], slot_num[hit], slot_rs[hit]};
        end
      end
      OP_FIND_FG: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_rs[i] == RS_FG) hit = i;
        end
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else r = '{STAT_OK, slot_pid[hit], slot_num[hit], slot_rs[hit]};
      end
      default: r.status = STAT_INVALID;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    job_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_pid[i] = '0;
        slot_num[i] = '0;
        slot_rs[i] = RS_UNDEF;
      end
      next_num = NUM_W'(1);
      expected_results.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result transaction arrived with no request outstanding.");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status ||
              out_ch.found_proc_id !== want.proc_id ||
              out_ch.found_job_number !== want.number ||
              out_ch.found_state !== want.state) begin
            fail_count <= fail_count + 1;
          end
          if (out_ch.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
          if (out_ch.found_proc_id !== want.proc_id)
            $error("found_proc_id: expected %0h, got %0h", want.proc_id,
                   out_ch.found_proc_id);
          if (out_ch.found_job_number !== want.number)
            $error("found_job_number: expected %0d, got %0d", want.number,
                   out_ch.found_job_number);
          if (out_ch.found_state !== want.state)
            $error("found_state: expected %0d, got %0d", want.state, out_ch.found_state);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(run_job_op(in_ch.opcode, in_ch.proc_id,
                                              in_ch.job_number, in_ch.run_state));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

@@ bench/job_slot_table_core_tb.sv @@
// Top of the job slot table bench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module job_slot_table_core_tb;
  import jst_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int RAND_ITEMS = 1085;
  localparam int POOL = 24;
  localparam int HOLD_AT = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam logic [PID_W-1:0] PID_MAX = '1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   tx_idle_pct = 10;
  int   rx_stall_pct = 83;
  int   quiet_cycles;

  jst_in_if  in_ch();
  jst_out_if out_ch();

  job_slot_table_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  job_slot_table_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_job(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                          input logic [NUM_W-1:0] jn, input logic [RS_W-1:0] rs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.proc_id    <= pid;
    in_ch.job_number <= jn;
    in_ch.run_state  <= rs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    begin
      int taken;
      int hold_left;
      bit hold_done;
      taken = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
        @(posedge clk);
        if (rst_n && in_ch.valid && in_ch.ready) taken++;
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else if (!hold_done && taken >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [PID_W-1:0] pid_pool[POOL];
    logic [PID_W-1:0] pid;
    logic [OP_W-1:0]  op;
    int pick;
    int add_cut;
    int del_cut;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.proc_id = '0;
    in_ch.job_number = '0;
    in_ch.run_state = RS_UNDEF;
    for (int i = 0; i < POOL; i++) begin
      do pid_pool[i] = PID_W'($urandom); while (pid_pool[i] == '0);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_job(OP_FIND_FG, '0, '0, RS_UNDEF);
    send_job(OP_DEL, 22'd5, '0, RS_UNDEF);
    send_job(OP_ADD, '0, '0, RS_FG);
    send_job(OP_FIND_PID, '0, '0, RS_UNDEF);
    send_job(OP_SET_STATE, '0, '0, RS_BG);
    send_job(OP_DEL, '0, '0, RS_UNDEF);
    send_job(OP_FIND_NUM, '0, '0, RS_UNDEF);
    send_job(OP_ADD, PID_MAX, 5'd17, RS_FG);
    send_job(OP_ADD, 22'd1, '1, RS_STOPPED);
    send_job(OP_FIND_PID, PID_MAX, '0, RS_UNDEF);
    send_job(OP_FIND_NUM, '0, 5'd1, RS_UNDEF);
    send_job(OP_FIND_NUM, '0, 5'd17, RS_UNDEF);
    send_job(OP_FIND_FG, '0, '0, RS_UNDEF);
    send_job(OP_SET_STATE, PID_MAX, '0, RS_STOPPED);
    send_job(OP_FIND_FG, '0, '0, RS_UNDEF);
    send_job(OP_SPARE_A, PID_MAX, 5'd2, RS_BG);
    send_job(OP_SPARE_B, 22'd1, 5'd1, RS_FG);
    send_job(OP_DEL, 22'd1, '0, RS_UNDEF);
    send_job(OP_DEL, PID_MAX, '0, RS_UNDEF);
    send_job(OP_ADD, 22'h2AAAAA, '0, RS_BG);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        tx_idle_pct = 83;
        rx_stall_pct <= 10;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
      add_cut = ((n / 60) % 2 == 0) ? 45 : 10;
      del_cut = ((n / 60) % 2 == 0) ? 55 : 50;
      pick = $urandom_range(99);
      if (pick < add_cut) op = OP_ADD;
      else if (pick < del_cut) op = OP_DEL;
      else if (pick < 65) op = OP_FIND_PID;
      else if (pick < 75) op = OP_FIND_NUM;
      else if (pick < 88) op = OP_SET_STATE;
      else if (pick < 98) op = OP_FIND_FG;
      else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      pick = $urandom_range(19);
      if (pick == 0) pid = '0;
      else if (pick == 1) pid = PID_W'($urandom);
      else pid = pid_pool[$urandom_range(POOL - 1)];
      send_job(op, pid, NUM_W'($urandom_range(17)), RS_W'($urandom_range(3)));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/jst_pkg.sv
src/jst_in_if.sv
src/jst_out_if.sv
src/jst_slot_store.sv
src/job_slot_table_core.sv
bench/job_slot_table_core_checker.sv
bench/job_slot_table_core_tb.sv
